[sv/ms_pkg.sv]
// ----------------------------------------------------------------------------
// ms_pkg
// Shared types and constants of the merge sorter: the default capacity, the
// controller state encoding and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ms_pkg;

   localparam int MS_MAX_ITEMS = 64;
   localparam int MS_DATA_W    = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_PRIME,
      ST_MERGE,
      ST_OUT_PRIME,
      ST_OUT
   } ms_state_type;

   typedef struct packed {
      logic load;
      logic pass_init;
      logic run_prime;
      logic merge;
      logic next_run;
      logic next_pass;
      logic out_prime;
      logic out_phase;
      logic out_step;
      logic clear;
   } ms_cmd_type;

   typedef struct packed {
      logic pass_needed;
      logic run_end;
      logic set_end;
      logic out_last;
   } ms_status_type;

endpackage

[sv/ms_datapath.sv]
// ----------------------------------------------------------------------------
// ms_datapath
// Two value stores with two registered read ports each, the run and merge
// index registers, the signed compare that picks the next merged value, and
// the fill count and overflow flag of the current set.
// ----------------------------------------------------------------------------
module ms_datapath
   import ms_pkg::*;
#(
   parameter int MAX_ITEMS = MS_MAX_ITEMS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ms_cmd_type           cmd,
   input  logic [MS_DATA_W-1:0] in_value,
   output ms_status_type        status,
   output logic [MS_DATA_W-1:0] out_value,
   output logic                 out_overflow
);

   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   // The run width doubles past the count on the final pass, so it needs one
   // bit more than the count when the capacity is not a power of two.
   localparam int WID_W  = CNT_W + 1;

   logic [MS_DATA_W-1:0] mem_a [MAX_ITEMS];
   logic [MS_DATA_W-1:0] mem_b [MAX_ITEMS];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [WID_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             src_sel_ff, src_sel_in;

   logic [MS_DATA_W-1:0] rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;

   logic [ADDR_W-1:0]    rd0_addr, rd1_addr, wr_addr;
   logic [MS_DATA_W-1:0] wr_data;
   logic                 wr_a_en, wr_b_en;

   logic [MS_DATA_W-1:0] src0, src1, merge_data;
   logic                 take_left;
   logic [CNT_W-1:0]     i_inc, j_inc, k_inc;
   logic [CNT_W:0]       sum_mid;
   logic [CNT_W+1:0]     sum_hi;
   logic [CNT_W-1:0]     run_mid, run_hi;

   // Store B holds the source of a pass when src_sel_ff is set.
   assign src0 = src_sel_ff ? rd_b0_ff : rd_a0_ff;
   assign src1 = src_sel_ff ? rd_b1_ff : rd_a1_ff;

   // An exhausted run never wins; on equal values the left run goes first.
   assign take_left  = (j_ff == hi_ff) ||
                       ((i_ff != mid_ff) && ($signed(src0) <= $signed(src1)));
   assign merge_data = take_left ? src0 : src1;

   assign i_inc = CNT_W'(i_ff + 1'b1);
   assign j_inc = CNT_W'(j_ff + 1'b1);
   assign k_inc = CNT_W'(k_ff + 1'b1);

   assign sum_mid = {1'b0, lo_ff} + width_ff;
   assign sum_hi  = {2'b0, lo_ff} + {width_ff, 1'b0};
   assign run_mid = (sum_mid >= {1'b0, count_ff}) ? count_ff : sum_mid[CNT_W-1:0];
   assign run_hi  = (sum_hi >= {2'b0, count_ff}) ? count_ff : sum_hi[CNT_W-1:0];

   always_comb begin
      count_in   = count_ff;
      drop_in    = drop_ff;
      width_in   = width_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      src_sel_in = src_sel_ff;
      rd0_addr   = i_ff[ADDR_W-1:0];
      rd1_addr   = j_ff[ADDR_W-1:0];
      wr_addr    = k_ff[ADDR_W-1:0];
      wr_data    = merge_data;
      wr_a_en    = 1'b0;
      wr_b_en    = 1'b0;

      if (cmd.load) begin
         if (count_ff < CNT_W'(MAX_ITEMS)) begin
            wr_a_en  = 1'b1;
            wr_addr  = count_ff[ADDR_W-1:0];
            wr_data  = in_value;
            count_in = CNT_W'(count_ff + 1'b1);
         end else begin
            drop_in = 1'b1;
         end
      end

      if (cmd.pass_init) begin
         width_in   = WID_W'(1);
         lo_in      = '0;
         src_sel_in = 1'b0;
      end

      if (cmd.run_prime) begin
         i_in     = lo_ff;
         j_in     = run_mid;
         k_in     = lo_ff;
         mid_in   = run_mid;
         hi_in    = run_hi;
         rd0_addr = lo_ff[ADDR_W-1:0];
         rd1_addr = run_mid[ADDR_W-1:0];
      end

      if (cmd.merge) begin
         wr_a_en = src_sel_ff;
         wr_b_en = !src_sel_ff;
         k_in    = k_inc;
         if (take_left) begin
            i_in     = i_inc;
            rd0_addr = i_inc[ADDR_W-1:0];
         end else begin
            j_in     = j_inc;
            rd1_addr = j_inc[ADDR_W-1:0];
         end
      end

      if (cmd.next_run) begin
         lo_in = hi_ff;
      end

      if (cmd.next_pass) begin
         lo_in      = '0;
         width_in   = {width_ff[WID_W-2:0], 1'b0};
         src_sel_in = !src_sel_ff;
      end

      if (cmd.out_prime) begin
         k_in     = '0;
         rd0_addr = '0;
      end

      // The read address follows the output index, one ahead on a handoff,
      // so the read register always holds the value on offer.
      if (cmd.out_phase) begin
         rd0_addr = k_ff[ADDR_W-1:0];
         if (cmd.out_step) begin
            k_in     = k_inc;
            rd0_addr = k_inc[ADDR_W-1:0];
         end
      end

      if (cmd.clear) begin
         count_in = '0;
         drop_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff   <= width_in;
      lo_ff      <= lo_in;
      mid_ff     <= mid_in;
      hi_ff      <= hi_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      src_sel_ff <= src_sel_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_a0_ff <= mem_a[rd0_addr];
      rd_a1_ff <= mem_a[rd1_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_b_en) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_b0_ff <= mem_b[rd0_addr];
      rd_b1_ff <= mem_b[rd1_addr];
   end

   assign status.pass_needed = (width_ff < {1'b0, count_ff});
   assign status.run_end     = (k_inc == hi_ff);
   assign status.set_end     = (hi_ff == count_ff);
   assign status.out_last    = (k_inc == count_ff);

   assign out_value    = src0;
   assign out_overflow = drop_ff;

endmodule

[sv/ms_ctrl.sv]
// ----------------------------------------------------------------------------
// ms_ctrl
// Controller of the merge sorter: loads a set, steps through the bottom-up
// merge passes run by run, then hands out the sorted set.
// ----------------------------------------------------------------------------
module ms_ctrl
   import ms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tlast,
   input  logic          rsp_tready,
   input  ms_status_type status,
   output logic          req_tready,
   output logic          rsp_tvalid,
   output ms_cmd_type    cmd
);

   ms_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.pass_init = 1'b1;
                  state_in      = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (status.pass_needed) begin
               state_in = ST_PRIME;
            end else begin
               state_in = ST_OUT_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.run_prime = 1'b1;
            state_in      = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            if (status.run_end) begin
               if (status.set_end) begin
                  cmd.next_pass = 1'b1;
                  state_in      = ST_PASS;
               end else begin
                  cmd.next_run = 1'b1;
                  state_in     = ST_PRIME;
               end
            end
         end
         ST_OUT_PRIME: begin
            cmd.out_prime = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid    = 1'b1;
            cmd.out_phase = 1'b1;
            if (rsp_tready) begin
               cmd.out_step = 1'b1;
               if (status.out_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

[sv/merge_sorter.sv]
// ----------------------------------------------------------------------------
// merge_sorter
// Collects signed values until a request marked last, sorts them ascending
// with stable bottom-up merge passes, and streams the sorted set out.
// ----------------------------------------------------------------------------
// A set of N values is loaded at one request per cycle. After the request
// marked last, the block runs ceil(log2 N) merge passes; each pass starts in
// ST_PASS, then primes each run pair in ST_PRIME and merges it in ST_MERGE.
// The sorted values then leave at one per cycle while rsp_tready is high,
// after a priming step in ST_OUT_PRIME. The merge rate is set by the
// single write port of each store, which takes one merged value per cycle.
// No request is taken from the last request of a set until the last sorted
// value has been taken. Values beyond MAX_ITEMS are dropped and every response
// of that set carries the overflow flag.
module merge_sorter
   import ms_pkg::*;
#(
   parameter int MAX_ITEMS = MS_MAX_ITEMS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [MS_DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic                 req_tlast,   // is_last
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [MS_DATA_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic                 rsp_tlast,   // last_out
   output logic                 rsp_tuser    // [0] overflow
);

   ms_cmd_type    cmd;
   ms_status_type status;

   ms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   ms_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .in_value     (req_tdata),
      .status       (status),
      .out_value    (rsp_tdata),
      .out_overflow (rsp_tuser)
   );

   assign rsp_tlast = status.out_last;

   // Loading and handing out never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response sides active together");

   // A request marked last ends loading.
   a_last_stops_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("loading continued after the last request");

   // Taking the last sorted value returns the block to loading.
   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("block did not return to loading after the last response");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the merge sorter. A driver feeds sets of signed
// values from a queue of pending requests, a monitor predicts the sorted burst
// of every accepted set and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import ms_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int CAPACITY    = (MS_MAX_ITEMS > STORE_DEPTH) ? STORE_DEPTH : MS_MAX_ITEMS;
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam int ITEM_TARGET = 420;
   localparam int PRINT_LIMIT = 20;

   typedef enum int {
      STYLE_WIDE,
      STYLE_TIES,
      STYLE_EDGE,
      STYLE_MIXED
   } value_style_type;

   typedef struct {
      logic [MS_DATA_W-1:0] value;
      logic                 last;
      bit                   wait_drain;
   } set_value_type;

   typedef struct {
      logic [MS_DATA_W-1:0] value;
      logic                 last;
      logic                 overflow;
   } sorted_value_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [MS_DATA_W-1:0] req_tdata  = '0;   // [31:0] value
   logic                 req_tlast  = 1'b0;  // is_last
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [MS_DATA_W-1:0] rsp_tdata;          // [31:0] sorted_value
   logic                 rsp_tlast;          // last_out
   logic                 rsp_tuser;          // [0] overflow

   set_value_type        pending_values[$];
   sorted_value_type     sorted_expect[$];

   logic [MS_DATA_W-1:0] stored_vals[STORE_DEPTH];
   int                   stored_count = 0;
   bit                   dropped_any  = 1'b0;

   bit                   req_taken     = 1'b0;
   bit                   rsp_taken     = 1'b0;
   bit                   calm          = 1'b0;
   int                   sets_accepted = 0;
   int                   sets_seen     = 0;
   int                   gap_left      = 0;
   int                   stall_left    = 0;
   int                   hold_left     = 0;
   int                   idle_cycles   = 0;
   int                   error_count   = 0;
   int                   queued_count  = 0;

   merge_sorter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // Stores one accepted request and, on the last one of a set, queues the
   // whole set in ascending order.
   task automatic absorb_request(input logic [MS_DATA_W-1:0] value, input logic last);
      logic signed [MS_DATA_W-1:0] work[STORE_DEPTH];
      logic signed [MS_DATA_W-1:0] pick;
      int                          j;
      sorted_value_type            entry;
      if (stored_count < CAPACITY) begin
         stored_vals[stored_count] = value;
         stored_count++;
      end else begin
         dropped_any = 1'b1;
      end
      if (last) begin
         // Equal values are indistinguishable, so a plain insertion sort gives
         // the same sequence as the stable merge.
         for (int i = 0; i < stored_count; i++) begin
            pick = stored_vals[i];
            j = i;
            while (j > 0 && work[j-1] > pick) begin
               work[j] = work[j-1];
               j--;
            end
            work[j] = pick;
         end
         for (int i = 0; i < stored_count; i++) begin
            entry.value    = work[i];
            entry.last     = (i == stored_count - 1);
            entry.overflow = dropped_any;
            sorted_expect.push_back(entry);
         end
         stored_count = 0;
         dropped_any  = 1'b0;
      end
   endtask

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [MS_DATA_W-1:0] draw_value(input value_style_type style);
      value_style_type pick;
      pick = style;
      if (style == STYLE_MIXED) begin
         pick = value_style_type'($urandom_range(0, 2));
      end
      case (pick)
         STYLE_TIES: begin
            return $urandom_range(0, 8) - 4;
         end
         STYLE_EDGE: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic queue_value(input logic [MS_DATA_W-1:0] value, input logic last,
                              input bit wait_drain);
      set_value_type item;
      item.value      = value;
      item.last       = last;
      item.wait_drain = wait_drain;
      pending_values.push_back(item);
      queued_count++;
   endtask

   task automatic queue_set(input int size, input value_style_type style, input bit wait_drain);
      for (int k = 0; k < size; k++) begin
         queue_value(draw_value(style), k == size - 1, wait_drain && k == 0);
      end
   endtask

   // Long stretches with no idling on either side.
   always @(posedge clock) begin
      if ($urandom_range(0, 49) == 0) begin
         calm <= ~calm;
      end
   end

   always @(negedge clock) begin : drive_req
      set_value_type item;
      logic          valid_next;
      valid_next = req_tvalid;
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         if (req_tvalid && req_taken) begin
            valid_next = 1'b0;
         end
         if (!valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_values.size() > 0 &&
                         !(pending_values[0].wait_drain && sorted_expect.size() != 0)) begin
               item = pending_values.pop_front();
               req_tdata  <= item.value;
               req_tlast  <= item.last;
               valid_next = 1'b1;
               gap_left   = draw_gap();
            end
         end
      end
      req_tvalid <= valid_next;
   end

   always @(negedge clock) begin : drive_rsp
      logic ready_next;
      ready_next = 1'b0;
      if (!reset) begin
         // Every ninth set the receiver holds off for a long stretch, which
         // keeps the block busy while the next request waits at the input.
         if (sets_accepted != sets_seen) begin
            sets_seen = sets_accepted;
            if (sets_seen % 9 == 4) begin
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            if (rsp_taken) begin
               stall_left = draw_gap();
            end
            if (stall_left > 0) begin
               stall_left--;
            end else begin
               ready_next = 1'b1;
            end
         end
      end
      rsp_tready <= ready_next;
   end

   always @(posedge clock) begin : monitor
      sorted_value_type want;
      req_taken <= req_tvalid && req_tready;
      rsp_taken <= rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_expect.size() == 0) begin
               report_mismatch($sformatf("response %h with nothing expected", rsp_tdata));
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_tdata !== want.value) begin
                  report_mismatch($sformatf("sorted_value %h, expected %h",
                                            rsp_tdata, want.value));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last_out %b, expected %b on value %h",
                                            rsp_tlast, want.last, want.value));
               end
               if (rsp_tuser !== want.overflow) begin
                  report_mismatch($sformatf("overflow %b, expected %b on value %h",
                                            rsp_tuser, want.overflow, want.value));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_request(req_tdata, req_tlast);
            if (req_tlast) begin
               sets_accepted <= sets_accepted + 1;
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int set_index;
      int size;

      // Directed sets: single extremes, reversed pair, all edge values,
      // duplicates in both runs, an already sorted set and four random edge values.
      queue_value(32'h7FFF_FFFF, 1'b1, 1'b0);
      queue_value(32'h8000_0000, 1'b1, 1'b0);
      queue_value(32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_value(32'h8000_0000, 1'b1, 1'b0);
      queue_value(32'h0000_0000, 1'b0, 1'b1);
      queue_value(32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_value(32'h0000_0001, 1'b0, 1'b0);
      queue_value(32'h8000_0000, 1'b0, 1'b0);
      queue_value(32'h7FFF_FFFF, 1'b1, 1'b0);
      queue_value(32'd3, 1'b0, 1'b0);
      queue_value(32'd3, 1'b0, 1'b0);
      queue_value(-32'sd3, 1'b0, 1'b0);
      queue_value(32'd3, 1'b0, 1'b0);
      queue_value(-32'sd3, 1'b0, 1'b0);
      queue_value(32'd0, 1'b1, 1'b0);
      queue_value(-32'sd100, 1'b0, 1'b0);
      queue_value(32'd5, 1'b0, 1'b0);
      queue_value(32'd70000, 1'b1, 1'b0);
      queue_set(4, STYLE_EDGE, 1'b0);

      // Exactly full, then overflowing so that the request marked last is
      // itself dropped, then the rest random with rare large sets.
      queue_set(CAPACITY, STYLE_WIDE, 1'b1);
      queue_set(CAPACITY + 2, STYLE_MIXED, 1'b0);
      set_index = 0;
      while (queued_count < ITEM_TARGET) begin
         size = ($urandom_range(0, 11) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 8)
                                             : $urandom_range(1, 12);
         queue_set(size, value_style_type'($urandom_range(0, 3)), set_index % 7 == 0);
         set_index++;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_values.size() > 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (sorted_expect.size() > 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && sorted_expect.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
